// ===== src/dhmf_pkg.sv =====
// Package for the 5x5 depth hole filler: geometry limits, widths, register codes,
// the window record passed from the front end to the filter, and the mode-pick helper.
// No dependencies.
package dhmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DEPTH_W     = 11;
	localparam int CFG_DIM_W   = 11;
	localparam int INNER_THR_W = 4;
	localparam int OUTER_THR_W = 5;
	localparam int IDX_W       = 8;
	localparam int BUS_W       = ((DEPTH_W + 7) / 8) * 8;

	localparam int WIN    = 5;
	localparam int RADIUS = 2;
	localparam int NB_N   = WIN * WIN - 1;
	localparam int LINES  = WIN - 1;
	localparam int CNT_W  = $clog2(NB_N + 1);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 4);
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CRD_W = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 2;

	// Neighbor k is window position k, or k+1 past the center; these sit in the 3x3 ring.
	localparam logic [NB_N-1:0] INNER_MASK = 24'h0399C0;

	localparam logic [CFG_DIM_W-1:0]   WIDTH_RST     = 11'd320;
	localparam logic [CFG_DIM_W-1:0]   HEIGHT_RST    = 11'd240;
	localparam logic [INNER_THR_W-1:0] INNER_THR_RST = 4'd2;
	localparam logic [OUTER_THR_W-1:0] OUTER_THR_RST = 5'd2;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH     = 8'd0,
		REG_HEIGHT    = 8'd1,
		REG_INNER_THR = 8'd2,
		REG_OUTER_THR = 8'd3
	} reg_idx_t;

	typedef logic [DEPTH_W-1:0] depth_t;

	typedef struct packed {
		logic [DIM_W-1:0]       width;
		logic [DIM_W-1:0]       height;
		logic [INNER_THR_W-1:0] inner_thr;
		logic [OUTER_THR_W-1:0] outer_thr;
	} cfg_t;

	// Neighbors outside the frame are already forced to zero, so they drop out like holes.
	typedef struct packed {
		depth_t [NB_N-1:0] nb;
		depth_t            centre;
		logic              last;
	} win_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		depth_t           val;
	} cand_t;

	// The lower-indexed candidate wins unless the other one is strictly more frequent.
	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.cnt > a.cnt) ? b : a;
	endfunction

endpackage

// ===== src/dhmf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dhmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== src/dhmf_front.sv =====
// Front end: accepts pixels, tracks the stream position, runs the four line buffers
// and the 5x5 window, and pushes a masked window record for every emitted center.
// Depends on dhmf_pkg and dhmf_ram.
module dhmf_front import dhmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  depth_t    in_depth,
	input  logic      in_flush,
	output logic      push,
	output win_item_t push_item,
	input  logic      q_full
);
	localparam logic signed [CRD_W-1:0] ONE   = CRD_W'(1);
	localparam logic signed [CRD_W-1:0] TWO   = CRD_W'(2);
	localparam logic signed [CRD_W-1:0] THREE = CRD_W'(3);
	localparam logic signed [CRD_W-1:0] ZERO  = '0;

	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;

	logic                    v_s1, emit_s1, last_s1, byp_s1;
	logic [COL_W-1:0]        c_s1;
	depth_t                  pix_s1;
	logic signed [CRD_W-1:0] yc_s1, xc_s1;
	logic [LINES*DEPTH_W-1:0] bypd_s1, ram_rdata, ram_wdata, rd;

	depth_t [WIN-1:0][WIN-1:0] win_q, win_n;
	depth_t [WIN-1:0] col;

	logic signed [CRD_W-1:0] w_x, h_x, col_x, row_x, c_x, r_x, yc, xc, c_nxt;
	logic signed [CRD_W-1:0] col_n, row_n, yv, xv;
	logic restart, emit, last, accept, adv;
	depth_t pix;
	logic [WIN-1:0] row_ok, col_ok;

	assign adv      = v_s1 && (!emit_s1 || !q_full);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Position of the incoming item and the window center it completes.
	always_comb begin
		w_x   = CRD_W'(cfg.width);
		h_x   = CRD_W'(cfg.height);
		col_x = CRD_W'(column_q);
		row_x = CRD_W'(row_q);
		restart = row_x > h_x + TWO;
		c_x = (restart || col_x >= w_x) ? ZERO : col_x;
		r_x = restart ? ZERO : row_x;
		if (c_x >= TWO) begin
			yc = r_x - TWO;
			xc = c_x - TWO;
		end else begin
			yc = r_x - THREE;
			xc = w_x - TWO + c_x;
		end
		emit = (yc >= ZERO) && (yc < h_x);
		last = emit && (yc == h_x - ONE) && (xc == w_x - ONE);
		pix  = (r_x < h_x && !in_flush) ? in_depth : '0;
		c_nxt = c_x + ONE;
		if (last) begin
			col_n = ZERO;
			row_n = ZERO;
		end else if (c_nxt >= w_x) begin
			col_n = ZERO;
			row_n = r_x + ONE;
		end else begin
			col_n = c_nxt;
			row_n = r_x;
		end
	end

	always_comb begin
		rd = byp_s1 ? bypd_s1 : ram_rdata;
		for (int k = 0; k < LINES; k++) begin
			col[k] = rd[k*DEPTH_W +: DEPTH_W];
		end
		col[LINES] = pix_s1;
		for (int k = 0; k < LINES; k++) begin
			ram_wdata[k*DEPTH_W +: DEPTH_W] = col[k+1];
		end
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN - 1; j++) begin
				win_n[i][j] = win_q[i][j+1];
			end
			win_n[i][WIN-1] = col[i];
		end
	end

	// Mask neighbors that fall outside the frame.
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			yv = yc_s1 + CRD_W'(i - RADIUS);
			xv = xc_s1 + CRD_W'(i - RADIUS);
			row_ok[i] = (yv >= ZERO) && (yv < h_x);
			col_ok[i] = (xv >= ZERO) && (xv < w_x);
		end
		for (int p = 0; p < WIN * WIN; p++) begin
			if (p < NB_N / 2) begin
				push_item.nb[p] = (row_ok[p/WIN] && col_ok[p%WIN]) ? win_n[p/WIN][p%WIN] : '0;
			end else if (p > NB_N / 2) begin
				push_item.nb[p-1] = (row_ok[p/WIN] && col_ok[p%WIN]) ?
					win_n[p/WIN][p%WIN] : '0;
			end
		end
		push_item.centre = win_n[RADIUS][RADIUS];
		push_item.last   = last_s1;
	end

	assign push = adv && emit_s1;

	dhmf_ram #(.WIDTH(LINES*DEPTH_W), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (adv),
		.waddr (c_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (c_x[COL_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
			byp_s1   <= 1'b0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				column_q <= col_n[COL_W-1:0];
				row_q    <= row_n[ROW_W-1:0];
				// A column written this very cycle is read back through the bypass.
				byp_s1   <= adv && (c_s1 == c_x[COL_W-1:0]);
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				win_q <= win_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1    <= c_x[COL_W-1:0];
			pix_s1  <= pix;
			yc_s1   <= yc;
			xc_s1   <= xc;
			emit_s1 <= emit;
			last_s1 <= last;
			bypd_s1 <= ram_wdata;
		end
	end
endmodule

// ===== src/dhmf_queue.sv =====
// Two-entry queue of window records between the front end and the filter.
// Depends on dhmf_pkg.
module dhmf_queue import dhmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  win_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output win_item_t head
);
	win_item_t  mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end
endmodule

// ===== src/dhmf_back.sv =====
// Filter back end: neighbor frequencies and band counts, then a registered argmax
// tree, then the output register of the result stream.
// Depends on dhmf_pkg.
module dhmf_back import dhmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  win_item_t item,
	output logic      out_valid,
	input  logic      out_ready,
	output depth_t    out_depth,
	output logic      out_last
);
	localparam int GRP   = 6;
	localparam int NGRP  = NB_N / GRP;

	logic v_s1, v_s2, v_s3, rdy1, rdy2, rdy3;

	cand_t [NB_N-1:0] cand_s1;
	depth_t           centre_s1, centre_s2;
	logic             last_s1, last_s2, fill_s1, fill_s2;
	cand_t [NGRP-1:0] best_s2;

	logic [NB_N-1:0] nz, same;
	cand_t [NB_N-1:0] cand;
	logic [CNT_W-1:0] inner, outer;
	cand_t [NGRP-1:0] best;
	cand_t fin;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s3;

	always_comb begin
		for (int k = 0; k < NB_N; k++) begin
			nz[k] = item.nb[k] != '0;
		end
		for (int k = 0; k < NB_N; k++) begin
			for (int m = 0; m < NB_N; m++) begin
				same[m] = nz[m] && (item.nb[m] == item.nb[k]);
			end
			cand[k].cnt = CNT_W'($countones(same));
			cand[k].val = item.nb[k];
		end
		inner = CNT_W'($countones(nz & INNER_MASK));
		outer = CNT_W'($countones(nz & ~INNER_MASK));
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			best[g] = cand_s1[g*GRP];
			for (int k = 1; k < GRP; k++) begin
				best[g] = pick(best[g], cand_s1[g*GRP+k]);
			end
		end
		fin = best_s2[0];
		for (int g = 1; g < NGRP; g++) begin
			fin = pick(fin, best_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cand_s1   <= cand;
			centre_s1 <= item.centre;
			last_s1   <= item.last;
			fill_s1   <= (CNT_W'(cfg.inner_thr) <= inner) || (CNT_W'(cfg.outer_thr) <= outer);
		end
		if (rdy2 && v_s1) begin
			best_s2   <= best;
			centre_s2 <= centre_s1;
			last_s2   <= last_s1;
			fill_s2   <= fill_s1;
		end
		if (rdy3 && v_s2) begin
			if (centre_s2 != '0) begin
				out_depth <= centre_s2;
			end else begin
				out_depth <= fill_s2 ? fin.val : '0;
			end
			out_last <= last_s2;
		end
	end
endmodule

// ===== src/depth_hole_mode_fill_5x5.sv =====
// Top level of the 5x5 depth hole filler: configuration registers, front end, queue, filter.
// Depends on dhmf_pkg, dhmf_front, dhmf_queue and dhmf_back.
// Throughput is one pixel per cycle unless the output stalls. A pixel's result leaves 2*W+2
// items after it enters; an emitting item passes five register stages (line-buffer read stage,
// queue, two filter stages, output register) on its way to the output.
// Reset clears the stream position, window and pipeline valids and loads register defaults;
// the line buffers are not cleared, since rows outside the frame are masked by position.
module depth_hole_mode_fill_5x5 import dhmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BUS_W-1:0]   s_tdata,   // [10:0] depth_in, rest zero
	input  logic               s_tuser,   // [0] flush
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [BUS_W-1:0]   m_tdata,   // [10:0] depth_out, rest zero
	output logic               m_tlast,   // end_of_frame
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_DIM_W-1:0] cfg_data
);
	logic [CFG_DIM_W-1:0]   width_q, height_q;
	logic [INNER_THR_W-1:0] inner_thr_q;
	logic [OUTER_THR_W-1:0] outer_thr_q;
	cfg_t cfg;

	logic      push, q_full, q_ne, pop;
	win_item_t push_item, head;
	depth_t    out_depth;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			inner_thr_q <= INNER_THR_RST;
			outer_thr_q <= OUTER_THR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				REG_INNER_THR: inner_thr_q <= cfg_data[INNER_THR_W-1:0];
				REG_OUTER_THR: outer_thr_q <= cfg_data[OUTER_THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Geometry is clamped to at least three; width to at most the line-buffer size, height to MAX_HEIGHT.
	always_comb begin
		if (width_q < CFG_DIM_W'(3)) begin
			cfg.width = DIM_W'(3);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = DIM_W'(width_q);
		end
		if (height_q < CFG_DIM_W'(3)) begin
			cfg.height = DIM_W'(3);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			cfg.height = DIM_W'(MAX_HEIGHT);
		end else begin
			cfg.height = DIM_W'(height_q);
		end
		cfg.inner_thr = inner_thr_q;
		cfg.outer_thr = outer_thr_q;
	end

	dhmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_depth  (s_tdata[DEPTH_W-1:0]),
		.in_flush  (s_tuser),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	dhmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.head      (head)
	);

	logic back_ready;
	assign pop = q_ne && back_ready;

	dhmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (q_ne),
		.in_ready  (back_ready),
		.item      (head),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_depth (out_depth),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(BUS_W-DEPTH_W){1'b0}}, out_depth};
endmodule

// ===== src/dhmf_checker.sv =====
// Port-level checks for the depth hole filler, bound to the top level.
// Depends on dhmf_pkg.
module dhmf_checker import dhmf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [BUS_W-1:0] m_tdata,
	input logic             m_tlast,
	input logic             cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[BUS_W-1:DEPTH_W] == '0)
		else $error("padding bits of result are not zero");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");
endmodule

bind depth_hole_mode_fill_5x5 dhmf_checker u_dhmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);
